### sv/power_easing_curve_macros.svh
// Assertion helpers used by the easing curve top level.
`ifndef POWER_EASING_CURVE_MACROS_SVH
`define POWER_EASING_CURVE_MACROS_SVH

// Antecedent now, consequent a fixed number of cycles later.
`define PEC_ASSERT_AFTER(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ## (dly) (cons)) else $error("delayed check failed");

// Consequent now requires the condition a fixed number of cycles back.
`define PEC_ASSERT_PAST(label, cons, dly, ante) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cons) |-> $past((ante), dly)) else $error("history check failed");

`endif

### sv/pec_pkg.sv
package pec_pkg;

    typedef enum logic [1:0] {
        DIR_IN    = 2'd0,
        DIR_OUT   = 2'd1,
        DIR_INOUT = 2'd2
    } t_dir;

    typedef enum logic [2:0] {
        REG_POWER     = 3'd0,
        REG_DIRECTION = 3'd1,
        REG_DURATION  = 3'd2,
        REG_START     = 3'd3,
        REG_CHANGE    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [2:0] mul_cnt;  // number of extra multiplies, 0..4
        t_dir       dir;
    } t_curve_cfg;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    localparam int unsigned DIV_STAGES  = 17;
    localparam int unsigned PWR_STAGES  = 6;
    localparam int unsigned SCL_STAGES  = 2;
    localparam int unsigned PEC_LATENCY = DIV_STAGES + PWR_STAGES + SCL_STAGES;

endpackage

### sv/pec_divider.sv
module pec_divider
    import pec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [15:0] i_t,
    input  logic [15:0] i_d,
    output logic        o_vld,
    output logic        o_clp,
    output logic [16:0] o_quo
);

    logic [15:0] r_rem [0:16];
    logic [16:0] r_quo [0:16];
    logic        r_vld [0:16];
    logic        r_clp [0:16];

    logic        n_clp;
    logic [15:0] n_tc;
    logic        n_q16;

    // clamp, then take the integer quotient bit
    always_comb begin
        n_clp = i_t > i_d;
        n_tc  = n_clp ? i_d : i_t;
        n_q16 = (n_tc == i_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clp[0] <= n_clp;
        r_rem[0] <= n_q16 ? 16'd0 : n_tc;
        r_quo[0] <= {16'd0, n_q16};
    end

    for (genvar s = 1; s < 17; s++) begin : g_bit
        logic [16:0] n_rem2;
        logic [16:0] n_diff;
        logic        n_ge;

        always_comb begin
            n_rem2 = {r_rem[s-1], 1'b0};
            n_diff = n_rem2 - {1'b0, i_d};
            n_ge   = n_rem2 >= {1'b0, i_d};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_clp[s] <= r_clp[s-1];
            r_rem[s] <= n_ge ? n_diff[15:0] : n_rem2[15:0];
            r_quo[s] <= {r_quo[s-1][15:0], n_ge};
        end
    end

    assign o_vld = r_vld[16];
    assign o_clp = r_clp[16];
    assign o_quo = r_quo[16];

endmodule

### sv/pec_power.sv
module pec_power
    import pec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_curve_cfg  i_cfg,
    input  logic        i_vld,
    input  logic        i_clp,
    input  logic [16:0] i_u,
    output logic        o_vld,
    output logic        o_clp,
    output logic [30:0] o_f
);

    logic [30:0] r_p  [0:4];
    logic [30:0] r_w  [0:3];
    logic        r_lo [0:4];
    logic        r_vld [0:5];
    logic        r_clp [0:5];
    logic [30:0] r_f;

    logic [16:0] n_inv;
    logic        n_lo;
    logic [30:0] n_w;
    logic [30:0] n_f;

    // pick the base of the power from direction and half
    always_comb begin
        n_inv = ONE_Q16 - i_u;
        n_lo  = !i_u[16] && !i_u[15];
        unique case (i_cfg.dir)
            DIR_IN:    n_w = {i_u, 14'd0};
            DIR_OUT:   n_w = {n_inv, 14'd0};
            DIR_INOUT: n_w = n_lo ? {i_u[15:0], 15'd0} : {n_inv[15:0], 15'd0};
            default:   n_w = {i_u, 14'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clp[0] <= i_clp;
        r_lo[0]  <= n_lo;
        r_p[0]   <= n_w;
        r_w[0]   <= n_w;
    end

    for (genvar k = 1; k < 5; k++) begin : g_mul
        logic [61:0] n_prod;

        assign n_prod = 62'(r_p[k-1]) * 62'(r_w[k-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        // multiply only while the exponent asks for it, else pass through
        always_ff @(posedge i_clk) begin
            r_clp[k] <= r_clp[k-1];
            r_lo[k]  <= r_lo[k-1];
            r_p[k]   <= (3'(k - 1) < i_cfg.mul_cnt) ? n_prod[60:30] : r_p[k-1];
        end

        // the last multiply stage needs no base further down
        if (k < 4) begin : g_base
            always_ff @(posedge i_clk) begin
                r_w[k] <= r_w[k-1];
            end
        end
    end

    always_comb begin
        unique case (i_cfg.dir)
            DIR_IN:    n_f = r_p[4];
            DIR_OUT:   n_f = ONE_Q30 - r_p[4];
            DIR_INOUT: n_f = r_lo[4] ? (r_p[4] >> 1) : ONE_Q30 - (r_p[4] >> 1);
            default:   n_f = r_p[4];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[5] <= 1'b0;
        end else begin
            r_vld[5] <= r_vld[4];
        end
    end

    always_ff @(posedge i_clk) begin
        r_clp[5] <= r_clp[4];
        r_f      <= n_f;
    end

    assign o_vld = r_vld[5];
    assign o_clp = r_clp[5];
    assign o_f   = r_f;

endmodule

### sv/pec_scale.sv
module pec_scale
    import pec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic               i_clp,
    input  logic        [30:0] i_f,
    input  logic signed [31:0] i_change,
    input  logic signed [31:0] i_start,
    output logic               o_vld,
    output logic               o_clp,
    output logic signed [31:0] o_value
);

    localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

    logic signed [62:0] n_prod;
    logic signed [62:0] r_prod;
    logic               r_vld1;
    logic               r_clp1;
    logic signed [33:0] n_sum;
    logic signed [31:0] n_value;
    logic               r_vld2;
    logic               r_clp2;
    logic signed [31:0] r_value;

    assign n_prod = 63'(i_change) * 63'($signed({1'b0, i_f}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // arithmetic shift floors toward minus infinity
    always_comb begin
        n_sum = {{2{i_start[31]}}, i_start} + {r_prod[62], r_prod[62:30]};
        priority if (n_sum > SAT_MAX) begin
            n_value = SAT_MAX[31:0];
        end else if (n_sum < SAT_MIN) begin
            n_value = SAT_MIN[31:0];
        end else begin
            n_value = n_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_clp1  <= i_clp;
        r_clp2  <= r_clp1;
        r_value <= n_value;
    end

    assign o_vld   = r_vld2;
    assign o_clp   = r_clp2;
    assign o_value = r_value;

endmodule

### sv/power_easing_curve.sv
// Power easing curve: eased = start + change * f(elapsed / duration),
// with f one of the in, out or in-out polynomial curves of power 1..5.
//
// Command channel: drive i_elapsed_time with start high; busy stays low,
// so a new time value is taken in every cycle, back to back.
// Result channel: o_done is high for one cycle with o_eased_value and
// o_time_clamped; there is no way to hold it, the receiver must take it.
// The result path is registered through the one-bit-per-stage quotient
// pipeline, then the base select, four multiply stages and curve fold,
// then the scale multiply and saturating add.
// Throughput is one item per cycle.
// Configuration goes through the APB port (registers at 4*i: power,
// direction, duration, start, change); write it only with the pipeline
// empty. pready is always high and reads return the register contents.
// Reset is synchronous: it drops every item in flight and restores the
// registers to power 1, direction in, duration 1, start 0, change 0.
`include "power_easing_curve_macros.svh"

module power_easing_curve
    import pec_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic        [15:0] i_elapsed_time,
    output logic               o_done,
    output logic signed [31:0] o_eased_value,
    output logic               o_time_clamped
);

    logic [2:0]         r_power;
    logic [1:0]         r_dir;
    logic [15:0]        r_duration;
    logic signed [31:0] r_start;
    logic signed [31:0] r_change;

    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [2:0]         n_power;
    logic [15:0]        n_dur;
    t_curve_cfg         curve_cfg;

    logic               div_vld;
    logic               div_clp;
    logic [16:0]        div_quo;
    logic               pwr_vld;
    logic               pwr_clp;
    logic [30:0]        pwr_f;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power    <= 3'd1;
            r_dir      <= DIR_IN;
            r_duration <= 16'd1;
            r_start    <= '0;
            r_change   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_POWER:     r_power    <= pwdata[2:0];
                REG_DIRECTION: r_dir      <= pwdata[1:0];
                REG_DURATION:  r_duration <= pwdata[15:0];
                REG_START:     r_start    <= pwdata;
                REG_CHANGE:    r_change   <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_POWER:     prdata = {29'd0, r_power};
            REG_DIRECTION: prdata = {30'd0, r_dir};
            REG_DURATION:  prdata = {16'd0, r_duration};
            REG_START:     prdata = r_start;
            REG_CHANGE:    prdata = r_change;
            default:       prdata = '0;
        endcase
    end

    // fold out-of-range settings onto the nearest legal curve
    always_comb begin
        priority if (r_power == 3'd0) begin
            n_power = 3'd1;
        end else if (r_power > 3'd5) begin
            n_power = 3'd5;
        end else begin
            n_power = r_power;
        end
        n_dur             = (r_duration == 16'd0) ? 16'd1 : r_duration;
        curve_cfg.mul_cnt = n_power - 3'd1;
        if (n_power == 3'd1) begin
            curve_cfg.dir = DIR_IN;
        end else if (r_dir == 2'd3) begin
            curve_cfg.dir = DIR_INOUT;
        end else begin
            curve_cfg.dir = t_dir'(r_dir);
        end
    end

    pec_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start && !busy),
        .i_t     (i_elapsed_time),
        .i_d     (n_dur),
        .o_vld   (div_vld),
        .o_clp   (div_clp),
        .o_quo   (div_quo)
    );

    pec_power u_pwr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (curve_cfg),
        .i_vld   (div_vld),
        .i_clp   (div_clp),
        .i_u     (div_quo),
        .o_vld   (pwr_vld),
        .o_clp   (pwr_clp),
        .o_f     (pwr_f)
    );

    pec_scale u_scl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (pwr_vld),
        .i_clp    (pwr_clp),
        .i_f      (pwr_f),
        .i_change (r_change),
        .i_start  (r_start),
        .o_vld    (o_done),
        .o_clp    (o_time_clamped),
        .o_value  (o_eased_value)
    );

    `PEC_ASSERT_AFTER(a_accept_to_done, start && !busy, PEC_LATENCY, o_done)
    `PEC_ASSERT_PAST(a_done_from_accept, o_done, PEC_LATENCY, start && !busy)
    `PEC_ASSERT_AFTER(a_zero_not_clamped,
        start && !busy && i_elapsed_time == 16'd0, PEC_LATENCY, o_done && !o_time_clamped)

endmodule

### test/power_easing_curve_tb.sv
`timescale 1ns / 1ps

module power_easing_curve_tb;
    import pec_pkg::*;

    typedef struct {
        logic signed [31:0] value;
        logic               clamped;
    } t_eased;

    // Register indices with no register behind them; writes must be dropped.
    localparam logic [2:0] UNMAPPED_LO = 3'd5;
    localparam logic [2:0] UNMAPPED_HI = 3'd7;

    class easing_checker;
        localparam longint SAT_HI = 64'sd2147483647;
        localparam longint SAT_LO = -64'sd2147483648;

        logic [2:0]         power;
        logic [1:0]         direction;
        logic [15:0]        duration;
        logic signed [31:0] start_val;
        logic signed [31:0] change_val;
        t_eased             pending_results[$];
        int                 errors;

        function new();
            power      = 3'd1;
            direction  = DIR_IN;
            duration   = 16'd1;
            start_val  = '0;
            change_val = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_POWER:     power      = data[2:0];
                REG_DIRECTION: direction  = data[1:0];
                REG_DURATION:  duration   = data[15:0];
                REG_START:     start_val  = data;
                REG_CHANGE:    change_val = data;
                default: ;
            endcase
        endfunction

        // w^n in Q1.30, truncated after every product
        function longint unsigned raise_q30(longint unsigned w, int n);
            longint unsigned p;
            p = w;
            for (int i = 1; i < n; i++)
                p = (p * w) >> 30;
            return p;
        endfunction

        function t_eased eased_value_for(logic [15:0] elapsed);
            longint unsigned t, d, u16, f, one_q30, one_q16;
            longint          prod, term, sum, cv, sv;
            int              n;
            logic [1:0]      dir;
            t_eased          r;
            one_q30 = 64'(ONE_Q30);
            one_q16 = 64'(ONE_Q16);
            d = (duration == 16'd0) ? 64'd1 : 64'(duration);
            n = int'(power);
            if (n < 1) n = 1;
            if (n > 5) n = 5;
            dir = direction;
            if (dir > DIR_INOUT) dir = DIR_INOUT;
            t = 64'(elapsed);
            r.clamped = 1'b0;
            if (t > d) begin
                t = d;
                r.clamped = 1'b1;
            end
            u16 = (t << 16) / d;
            if (n == 1) begin
                f = u16 << 14;
            end else if (dir == DIR_IN) begin
                f = raise_q30(u16 << 14, n);
            end else if (dir == DIR_OUT) begin
                f = one_q30 - raise_q30((one_q16 - u16) << 14, n);
            end else if (u16 < (one_q16 >> 1)) begin
                f = raise_q30(u16 << 15, n) >> 1;
            end else begin
                f = one_q30 - (raise_q30((one_q16 - u16) << 15, n) >> 1);
            end
            cv   = 64'(change_val);
            sv   = 64'(start_val);
            prod = cv * longint'(f);
            term = prod >>> 30;  // floor toward minus infinity
            sum  = sv + term;
            if (sum > SAT_HI) sum = SAT_HI;
            if (sum < SAT_LO) sum = SAT_LO;
            r.value = sum[31:0];
            return r;
        endfunction

        function void note_time(logic [15:0] elapsed);
            pending_results.push_back(eased_value_for(elapsed));
        endfunction

        function void check_result(logic signed [31:0] value, logic clamped);
            t_eased exp_r;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: eased_value %0d, time_clamped %0b",
                       value, clamped);
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (value !== exp_r.value) begin
                $error("eased_value: expected %0d, actual %0d", exp_r.value, value);
                errors++;
            end
            if (clamped !== exp_r.clamped) begin
                $error("time_clamped: expected %0b, actual %0b", exp_r.clamped, clamped);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [4:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start          = 1'b0;
    logic        busy;
    logic [15:0] i_elapsed_time = '0;
    logic        o_done;
    logic signed [31:0] o_eased_value;
    logic        o_time_clamped;

    easing_checker tracker = new();

    power_easing_curve DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_elapsed_time (i_elapsed_time),
        .o_done         (o_done),
        .o_eased_value  (o_eased_value),
        .o_time_clamped (o_time_clamped)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) tracker.note_time(i_elapsed_time);
            if (o_done) tracker.check_result(o_eased_value, o_time_clamped);
        end
    end

    task automatic send_time(input logic [15:0] elapsed, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_elapsed_time <= elapsed;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold off until every pending result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_curve(input logic [2:0] pwr, input logic [1:0] dir,
                             input logic [15:0] dur, input logic [31:0] base,
                             input logic [31:0] delta);
        reg_write(REG_POWER, {29'd0, pwr});
        reg_write(REG_DIRECTION, {30'd0, dir});
        reg_write(REG_DURATION, {16'd0, dur});
        reg_write(REG_START, base);
        reg_write(REG_CHANGE, delta);
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [2:0]  pwr;
        logic [1:0]  dir;
        logic [15:0] dur;
        logic [31:0] hi;
        bit          burst;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: linear, duration 1, zero span
        send_time(16'd0, 0);
        send_time(16'd1, 0);
        send_time(16'd2, 0);
        send_time(16'hFFFF, 0);
        drain();

        // power zero acts as linear, duration zero as one, saturate high
        set_curve(3'd0, DIR_OUT, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_time(16'd0, 0);
        send_time(16'd1, 0);
        send_time(16'hFFFF, 1);
        drain();

        // power above five and direction three, saturate low
        set_curve(3'd7, 2'd3, 16'hFFFF, 32'h8000_0000, 32'h8000_0000);
        send_time(16'd0, 0);
        send_time(16'h7FFF, 0);
        send_time(16'h8000, 0);
        send_time(16'hFFFF, 0);
        drain();

        set_curve(3'd2, DIR_INOUT, 16'd2, 32'hFFFF_FFFF, 32'd1);
        send_time(16'd0, 0);
        send_time(16'd1, 0);
        send_time(16'd2, 0);
        send_time(16'd3, 0);
        drain();

        // unmapped registers must leave the curve alone
        set_curve(3'd3, DIR_IN, 16'd1000, 32'h0001_0000, 32'hFF00_0000);
        reg_write(UNMAPPED_LO, 32'hFFFF_FFFF);
        reg_write(UNMAPPED_HI, 32'h0000_0000);
        @(posedge i_clk);
        send_time(16'd499, 0);
        send_time(16'd500, 0);
        send_time(16'd501, 2);
        send_time(16'd1000, 0);
        send_time(16'd1001, 0);
        drain();

        for (int ph = 0; ph < 41; ph++) begin
            pwr = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 5));
            dir = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0:       dur = 16'($urandom_range(1, 16));
                1:       dur = 16'($urandom_range(17, 1000));
                2:       dur = 16'($urandom());
                3:       dur = 16'hFFFF;
                default: dur = 16'($urandom_range(0, 3));
            endcase
            set_curve(pwr, dir, dur, pick_q16(), pick_q16());
            hi = (dur > 16'hFFF0) ? 32'hFFFF : {16'd0, dur} + 32'd8;
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 25; k++) begin
                if (k == 12 && $urandom_range(0, 2) == 0) drain();
                send_time(($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, hi)),
                          burst ? 0 : int'($urandom_range(0, 5)));
            end
            drain();
        end

        repeat (PEC_LATENCY + 10) @(posedge i_clk);
        if (tracker.pending_results.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_results.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### power_easing_curve.f
+incdir+sv
sv/pec_pkg.sv
sv/pec_divider.sv
sv/pec_power.sv
sv/pec_scale.sv
sv/power_easing_curve.sv
test/power_easing_curve_tb.sv
